FILE: hw/rtl/fhwf_pkg.sv
// shared widths, codes and reset values of the window framer
package fhwf_pkg;

    // parameter defaults
    localparam int MAX_SIGNAL_DEF = 4096;
    localparam int MAX_FRAME_DEF  = 64;

    // sample and fixed-point format
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = 49;

    // transaction field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 16;
    localparam int PROD_W   = 32;
    localparam int POS_W    = 6;
    localparam int FRAME_W  = 16;

    // configuration register widths
    localparam int SL_W       = 13;
    localparam int FL_W       = 7;
    localparam int NF_W       = 16;
    localparam int FC_W       = 32;
    localparam int STEP_W     = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [SL_W-1:0]   SL_RESET   = SL_W'(4096);
    localparam logic [FL_W-1:0]   FL_RESET   = FL_W'(64);
    localparam logic [NF_W-1:0]   NF_RESET   = '0;
    localparam logic [FC_W-1:0]   FC_RESET   = '0;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // command codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_SAMPLE = 2'd0,
        OP_LOAD_WINDOW = 2'd1,
        OP_RESTART     = 2'd2,
        OP_EMIT        = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SIGNAL_LENGTH = 3'd0,
        REG_FRAME_LENGTH  = 3'd1,
        REG_NUM_FRAMES    = 3'd2,
        REG_FIRST_CENTER  = 3'd3,
        REG_STEP_SIZE     = 3'd4,
        REG_COMPLEX_MODE  = 3'd5
    } reg_index_t;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CFG = 1'b1;

endpackage

FILE: hw/rtl/fhwf_if.sv
// handshake channels of the window framer: configuration, command and result
interface fhwf_cfg_if
    import fhwf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

interface fhwf_cmd_if
    import fhwf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  real_value;
    logic signed [VALUE_W-1:0]  imag_value;

    modport source (output valid, output opcode, output index, output real_value,
                    output imag_value, input ready);
    modport sink   (input valid, input opcode, input index, input real_value,
                    input imag_value, output ready);
endinterface

interface fhwf_res_if
    import fhwf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [PROD_W-1:0]  product_real;
    logic signed [PROD_W-1:0]  product_imag;
    logic [POS_W-1:0]          position;
    logic [FRAME_W-1:0]        frame_index;
    logic                      last;
    logic                      status;

    modport source (output valid, output product_real, output product_imag,
                    output position, output frame_index, output last,
                    output status, input ready);
    modport sink   (input valid, input product_real, input product_imag,
                    input position, input frame_index, input last,
                    input status, output ready);
endinterface

FILE: hw/rtl/fractional_hop_window_framer_core.sv
// window framer with fractional hop: sample and window stores, frame sequencer
//
// Samples (real and imaginary part in one word) and window coefficients are
// loaded into two synchronous memories; a restart command loads the Q.16
// center accumulator from first_center and clears the frame count. Each emit
// command streams frame_length windowed products, one per cycle while the
// result side does not stall, limited by the single read port of the sample
// memory: setup (center rounding, then start index and hop), then frame_length
// issues, then the read stage empties before the next command is taken. An
// emit with an invalid configuration returns a single result with status set
// and last high; an emit after num_frames frames returns nothing. The stores
// are not cleared at reset: an entry must be loaded before a frame reads it,
// otherwise its products are undefined. Configuration writes are taken in any
// cycle and must only be made while the block is idle.
module fractional_hop_window_framer_core
    import fhwf_pkg::*;
#(
    parameter int MAX_SIGNAL = MAX_SIGNAL_DEF,
    parameter int MAX_FRAME  = MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fhwf_cfg_if.sink    cfg,
    fhwf_cmd_if.sink    cmd,
    fhwf_res_if.source  res
);

    localparam int SIG_AW  = (MAX_SIGNAL > 1) ? $clog2(MAX_SIGNAL) : 1;
    localparam int WIN_AW  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int SIDX_W  = (SIG_AW > INDEX_W) ? SIG_AW : INDEX_W;
    localparam int WIDX_W  = (WIN_AW > INDEX_W) ? WIN_AW : INDEX_W;
    localparam int CS_W    = ACC_W + 1 - FRAC_BITS;
    localparam int LIM_W   = ((FC_W > SL_W + FRAC_BITS) ? FC_W : SL_W + FRAC_BITS) + 1;
    localparam int WORD_W  = 2 * SAMPLE_BITS;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ERR    = 5'b00010,
        S_CENTER = 5'b00100,
        S_START  = 5'b01000,
        S_RUN    = 5'b10000
    } state_t;

    // configuration registers
    logic [SL_W-1:0]   signal_length_reg;
    logic [FL_W-1:0]   frame_length_reg;
    logic [NF_W-1:0]   num_frames_reg;
    logic [FC_W-1:0]   first_center_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic              complex_mode_reg;

    // sequencer state
    state_t                    state_reg;
    state_t                    state_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [FRAME_W-1:0]        frames_done_reg;
    logic signed [CS_W-1:0]    cs_reg;
    logic signed [CS_W-1:0]    s_reg;
    logic [POS_W-1:0]          l_reg;

    // read stage
    logic                      b_vld_reg;
    logic                      b_err_reg;
    logic                      b_inr_reg;
    logic                      b_last_reg;
    logic [POS_W-1:0]          b_pos_reg;
    logic [FRAME_W-1:0]        b_frame_reg;
    logic [WORD_W-1:0]         sig_rd_reg;
    logic [SAMPLE_BITS-1:0]    win_rd_reg;

    // output register
    logic                      out_vld_reg;
    logic signed [PROD_W-1:0]  prod_re_reg;
    logic signed [PROD_W-1:0]  prod_im_reg;
    logic [POS_W-1:0]          pos_out_reg;
    logic [FRAME_W-1:0]        frame_out_reg;
    logic                      last_out_reg;
    logic                      status_out_reg;

    // memories
    logic [WORD_W-1:0]         sig_mem [MAX_SIGNAL];
    logic [SAMPLE_BITS-1:0]    win_mem [MAX_FRAME];

    logic                      cmd_fire;
    logic                      adv;
    logic                      run_issue;
    logic                      err_issue;
    logic                      issue_last;
    logic                      issue_inr;
    logic                      cfg_ok;
    logic                      frames_left;
    logic [SL_W-1:0]           nm1;
    logic signed [LIM_W-1:0]   center_lim;
    logic signed [LIM_W-1:0]   fc_ext;
    logic signed [ACC_W:0]     rnd_sum;
    logic [SIDX_W-1:0]         sidx_ext;
    logic [WIDX_W-1:0]         widx_ext;
    logic                      sig_wr;
    logic                      win_wr;
    logic signed [WORD_W-1:0]  mul_re;
    logic signed [WORD_W-1:0]  mul_im;

    // handshakes
    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == S_IDLE) && !b_vld_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign adv       = !out_vld_reg || res.ready;
    assign run_issue = (state_reg == S_RUN) && adv;
    assign err_issue = (state_reg == S_ERR) && adv;

    // configuration check
    assign nm1        = signal_length_reg - SL_W'(1);
    assign center_lim = LIM_W'(nm1) << FRAC_BITS;
    assign fc_ext     = LIM_W'($signed(first_center_reg));
    assign cfg_ok     = (signal_length_reg != '0)
                     && (32'(signal_length_reg) <= MAX_SIGNAL)
                     && (frame_length_reg != '0)
                     && (SL_W'(frame_length_reg) < signal_length_reg)
                     && (32'(frame_length_reg) <= MAX_FRAME)
                     && (step_size_reg != '0)
                     && (fc_ext <= center_lim);
    assign frames_left = frames_done_reg < num_frames_reg;

    // round half away from zero: add half, minus one for negative values
    assign rnd_sum = {acc_reg[ACC_W-1], acc_reg} + HALF
                   - (ACC_W + 1)'(acc_reg[ACC_W-1]);

    // element issue
    assign issue_last = ({1'b0, l_reg} + FL_W'(1)) == frame_length_reg;
    assign issue_inr  = !s_reg[CS_W-1]
                     && (s_reg[CS_W-2:0] < (CS_W - 1)'(signal_length_reg));

    // load decode
    assign sidx_ext = SIDX_W'(cmd.index);
    assign widx_ext = WIDX_W'(cmd.index);
    assign sig_wr   = cmd_fire && (opcode_t'(cmd.opcode) == OP_LOAD_SAMPLE)
                   && (32'(cmd.index) < MAX_SIGNAL);
    assign win_wr   = cmd_fire && (opcode_t'(cmd.opcode) == OP_LOAD_WINDOW)
                   && (32'(cmd.index) < MAX_FRAME);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signal_length_reg <= SL_RESET;
            frame_length_reg  <= FL_RESET;
            num_frames_reg    <= NF_RESET;
            first_center_reg  <= FC_RESET;
            step_size_reg     <= STEP_RESET;
            complex_mode_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                REG_SIGNAL_LENGTH: signal_length_reg <= cfg.data[SL_W-1:0];
                REG_FRAME_LENGTH:  frame_length_reg  <= cfg.data[FL_W-1:0];
                REG_NUM_FRAMES:    num_frames_reg    <= cfg.data[NF_W-1:0];
                REG_FIRST_CENTER:  first_center_reg  <= cfg.data[FC_W-1:0];
                REG_STEP_SIZE:     step_size_reg     <= cfg.data[STEP_W-1:0];
                REG_COMPLEX_MODE:  complex_mode_reg  <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (opcode_t'(cmd.opcode) == OP_EMIT))
                begin
                    if (!cfg_ok)
                        state_next = S_ERR;
                    else if (frames_left)
                        state_next = S_CENTER;
                end
            end
            S_ERR:
            begin
                if (adv)
                    state_next = S_IDLE;
            end
            S_CENTER: state_next = S_START;
            S_START:  state_next = S_RUN;
            S_RUN:
            begin
                if (adv && issue_last)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            acc_reg         <= '0;
            frames_done_reg <= '0;
            cs_reg          <= '0;
            s_reg           <= '0;
            l_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_fire && (opcode_t'(cmd.opcode) == OP_RESTART))
            begin
                acc_reg         <= ACC_W'($signed(first_center_reg));
                frames_done_reg <= '0;
            end
            if (state_reg == S_CENTER)
                cs_reg <= rnd_sum[ACC_W:FRAC_BITS];
            if (state_reg == S_START)
            begin
                s_reg   <= cs_reg - CS_W'(frame_length_reg >> 1);
                l_reg   <= '0;
                acc_reg <= acc_reg + ACC_W'(step_size_reg);
            end
            if (run_issue)
            begin
                s_reg <= s_reg + CS_W'(1);
                l_reg <= l_reg + POS_W'(1);
                if (issue_last)
                    frames_done_reg <= frames_done_reg + FRAME_W'(1);
            end
        end
    end

    // sample memory: write on load, registered read on issue
    always_ff @(posedge clk)
    begin
        if (sig_wr)
            sig_mem[sidx_ext[SIG_AW-1:0]] <= {cmd.imag_value, cmd.real_value};
        if (run_issue)
            sig_rd_reg <= sig_mem[s_reg[SIG_AW-1:0]];
    end

    // window memory
    always_ff @(posedge clk)
    begin
        if (win_wr)
            win_mem[widx_ext[WIN_AW-1:0]] <= cmd.real_value;
        if (run_issue)
            win_rd_reg <= win_mem[l_reg[WIN_AW-1:0]];
    end

    // read stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg   <= 1'b0;
            b_err_reg   <= 1'b0;
            b_inr_reg   <= 1'b0;
            b_last_reg  <= 1'b0;
            b_pos_reg   <= '0;
            b_frame_reg <= '0;
        end
        else if (adv)
        begin
            b_vld_reg   <= run_issue || err_issue;
            b_err_reg   <= err_issue;
            b_inr_reg   <= run_issue && issue_inr;
            b_last_reg  <= err_issue || issue_last;
            b_pos_reg   <= err_issue ? '0 : l_reg;
            b_frame_reg <= err_issue ? '0 : frames_done_reg;
        end
    end

    // products
    assign mul_re = $signed(sig_rd_reg[SAMPLE_BITS-1:0]) * $signed(win_rd_reg);
    assign mul_im = $signed(sig_rd_reg[WORD_W-1:SAMPLE_BITS]) * $signed(win_rd_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_vld_reg)
        begin
            prod_re_reg    <= b_inr_reg ? PROD_W'(mul_re) : '0;
            prod_im_reg    <= (b_inr_reg && complex_mode_reg) ? PROD_W'(mul_im) : '0;
            pos_out_reg    <= b_pos_reg;
            frame_out_reg  <= b_frame_reg;
            last_out_reg   <= b_last_reg;
            status_out_reg <= b_err_reg ? STATUS_BAD_CFG : STATUS_OK;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.product_real = prod_re_reg;
    assign res.product_imag = prod_im_reg;
    assign res.position     = pos_out_reg;
    assign res.frame_index  = frame_out_reg;
    assign res.last         = last_out_reg;
    assign res.status       = status_out_reg;

`ifndef SYNTHESIS
    // an error result is a single element with no data
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (res.last && res.position == '0
            && res.product_real == '0 && res.product_imag == '0))
        else $error("error result carries data");

    // issue counter stays inside the frame
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ({1'b0, l_reg} < frame_length_reg))
        else $error("element index beyond frame length");

    // a valid emit with frames left starts the setup
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && opcode_t'(cmd.opcode) == OP_EMIT && cfg_ok && frames_left)
            |=> (state_reg == S_CENTER))
        else $error("emit did not start a frame");

    // frame count moves by one after the last element is issued
    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        (run_issue && issue_last)
            |=> (frames_done_reg == $past(frames_done_reg) + FRAME_W'(1)))
        else $error("frame count not advanced");
`endif

endmodule
